FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL modules; mbd_seq includes them.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MBD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MBD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/mbd_pkg.sv
package mbd_pkg;

   // Number of buttons sampled in one transaction
   localparam int BUTTON_COUNT = 4;
   localparam int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam int ID_W         = 3;
   localparam int TIME_W       = 32;
   localparam int POLL_W       = 16;
   localparam int THR_W        = 8;
   localparam int LONG_W       = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_INTERVAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS       = 2'd2;

   // Register reset values
   localparam logic [POLL_W-1:0] POLL_INTERVAL_RESET    = 16'd10;
   localparam logic [THR_W-1:0]  STABLE_THRESHOLD_RESET = 8'd3;
   localparam logic [LONG_W-1:0] LONG_PRESS_RESET       = 16'd1000;

   typedef enum logic [1:0] {
      KIND_PRESSED  = 2'd0,
      KIND_RELEASED = 2'd1,
      KIND_HELD     = 2'd2
   } event_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_PRESSED  = 2'd1,
      PH_HELD     = 2'd2,
      PH_RELEASED = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      SQ_IDLE  = 2'd0,
      SQ_CHECK = 2'd1,
      SQ_RUN   = 2'd2,
      SQ_FLUSH = 2'd3
   } seq_state_type;

   typedef struct packed {
      logic [BUTTON_COUNT-1:0] raw_levels;
      logic [TIME_W-1:0]       time_ms;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   button_id;
      logic [1:0]        event_kind;
      logic [TIME_W-1:0] duration_ms;
      logic              last_event;
   } rsp_type;

   // Sequencer control towards the button unit
   typedef struct packed {
      logic             step_en;
      logic             sel_poll;
      logic [IDX_W-1:0] idx;
   } unit_ctrl_type;

   // Event produced by one button step
   typedef struct packed {
      logic              valid;
      event_kind_type    kind;
      logic [TIME_W-1:0] dur;
      logic [ID_W-1:0]   id;
   } btn_event_type;

endpackage

FILE: hw/rtl/mbd_btn_unit.sv
module mbd_btn_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  mbd_pkg::unit_ctrl_type           ctrl,
   input  logic [mbd_pkg::BUTTON_COUNT-1:0] levels,
   input  logic [mbd_pkg::TIME_W-1:0]       now,
   input  logic [mbd_pkg::TIME_W-1:0]       last_poll,
   input  logic [mbd_pkg::THR_W-1:0]        stable_threshold,
   input  logic [mbd_pkg::LONG_W-1:0]       long_press_ms,
   output logic [mbd_pkg::TIME_W-1:0]       diff,
   output mbd_pkg::btn_event_type           evt
);
   import mbd_pkg::*;

   logic              prev_level_ff  [BUTTON_COUNT];
   logic [THR_W-1:0]  stable_count_ff[BUTTON_COUNT];
   phase_type         phase_ff       [BUTTON_COUNT];
   logic [TIME_W-1:0] press_start_ff [BUTTON_COUNT];

   logic              lvl;
   logic              pressed;
   logic              stable;
   logic              prev_level_in;
   logic [THR_W-1:0]  stable_count_in;
   phase_type         phase_in;
   logic              start_upd;

   // Shared subtractor: poll age in the check step, press age per button
   always_comb begin
      diff = now - (ctrl.sel_poll ? last_poll : press_start_ff[ctrl.idx]);
   end

   // Debounce counter and phase machine of the selected button
   always_comb begin
      lvl             = levels[ctrl.idx];
      pressed         = !lvl;
      prev_level_in   = prev_level_ff[ctrl.idx];
      stable_count_in = stable_count_ff[ctrl.idx];
      if (lvl == prev_level_ff[ctrl.idx]) begin
         if (stable_count_ff[ctrl.idx] < stable_threshold) begin
            stable_count_in = stable_count_ff[ctrl.idx] + THR_W'(1);
         end
      end else begin
         stable_count_in = '0;
         prev_level_in   = lvl;
      end
      stable = (stable_count_in >= stable_threshold);

      phase_in  = phase_ff[ctrl.idx];
      start_upd = 1'b0;
      evt.valid = 1'b0;
      evt.kind  = KIND_PRESSED;
      evt.dur   = diff;
      evt.id    = ID_W'(ctrl.idx) + ID_W'(1);
      unique case (phase_ff[ctrl.idx])
         PH_IDLE: begin
            if (stable && pressed) begin
               phase_in  = PH_PRESSED;
               start_upd = 1'b1;
               evt.valid = 1'b1;
               evt.kind  = KIND_PRESSED;
               evt.dur   = '0;
            end
         end
         PH_PRESSED: begin
            if (!pressed) begin
               phase_in  = PH_RELEASED;
               evt.valid = 1'b1;
               evt.kind  = KIND_RELEASED;
            end else if (diff > TIME_W'(long_press_ms)) begin
               phase_in  = PH_HELD;
               evt.valid = 1'b1;
               evt.kind  = KIND_HELD;
            end
         end
         PH_HELD: begin
            if (!pressed) begin
               phase_in = PH_IDLE;
            end
         end
         PH_RELEASED: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Commit the button state when the sequencer advances
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            prev_level_ff[i]   <= 1'b1;
            stable_count_ff[i] <= '0;
            phase_ff[i]        <= PH_IDLE;
            press_start_ff[i]  <= '0;
         end
      end else if (ctrl.step_en) begin
         prev_level_ff[ctrl.idx]   <= prev_level_in;
         stable_count_ff[ctrl.idx] <= stable_count_in;
         phase_ff[ctrl.idx]        <= phase_in;
         if (start_upd) begin
            press_start_ff[ctrl.idx] <= now;
         end
      end
   end

endmodule

FILE: hw/rtl/mbd_seq.sv
`include "assert_macros.svh"

module mbd_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mbd_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mbd_pkg::rsp_type                 rsp_payload,
   input  logic [mbd_pkg::POLL_W-1:0]       poll_interval_ms,
   output mbd_pkg::unit_ctrl_type           ctrl,
   output logic [mbd_pkg::BUTTON_COUNT-1:0] levels,
   output logic [mbd_pkg::TIME_W-1:0]       now,
   output logic [mbd_pkg::TIME_W-1:0]       last_poll,
   input  logic [mbd_pkg::TIME_W-1:0]       diff,
   input  mbd_pkg::btn_event_type           evt
);
   import mbd_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTON_COUNT - 1);

   seq_state_type           state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [BUTTON_COUNT-1:0] levels_ff, levels_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [TIME_W-1:0]       last_poll_ff, last_poll_in;
   logic                    pend_valid_ff, pend_valid_in;
   btn_event_type           pend_ff, pend_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_ff, out_in;
   logic                    out_free;
   logic                    stall;
   logic                    push;

   assign out_free = !out_valid_ff || rsp_ready;
   assign stall    = (state_ff == SQ_RUN) && evt.valid && pend_valid_ff && !out_free;

   assign req_ready   = (state_ff == SQ_IDLE);
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign levels      = levels_ff;
   assign now         = now_ff;
   assign last_poll   = last_poll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SQ_IDLE;
         idx_ff        <= '0;
         last_poll_ff  <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         last_poll_ff  <= last_poll_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
      now_ff    <= now_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
   end

   // Sequence: take sample, check poll age, step each button, flush last event
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      levels_in     = levels_ff;
      now_in        = now_ff;
      last_poll_in  = last_poll_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      push          = 1'b0;
      ctrl.step_en  = 1'b0;
      ctrl.sel_poll = 1'b0;
      ctrl.idx      = idx_ff;

      unique case (state_ff)
         SQ_IDLE: begin
            if (req_valid) begin
               levels_in = req_payload.raw_levels;
               now_in    = req_payload.time_ms;
               state_in  = SQ_CHECK;
            end
         end
         SQ_CHECK: begin
            ctrl.sel_poll = 1'b1;
            if (diff < TIME_W'(poll_interval_ms)) begin
               state_in = SQ_IDLE;
            end else begin
               last_poll_in = now_ff;
               idx_in       = '0;
               state_in     = SQ_RUN;
            end
         end
         SQ_RUN: begin
            if (!stall) begin
               ctrl.step_en = 1'b1;
               if (evt.valid) begin
                  // Hand the held-back event on; this one may be the last
                  if (pend_valid_ff) begin
                     push = 1'b1;
                     out_in.last_event = 1'b0;
                  end
                  pend_in       = evt;
                  pend_valid_in = 1'b1;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = SQ_FLUSH;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         SQ_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = SQ_IDLE;
            end else if (out_free) begin
               push              = 1'b1;
               out_in.last_event = 1'b1;
               pend_valid_in     = 1'b0;
               state_in          = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase

      if (push) begin
         out_valid_in       = 1'b1;
         out_in.button_id   = pend_ff.id;
         out_in.event_kind  = pend_ff.kind;
         out_in.duration_ms = pend_ff.dur;
      end
   end

   `MBD_ASSERT(a_idle_no_pending, req_ready |-> !pend_valid_ff, "event pending while idle")
   `MBD_ASSERT(a_push_into_free, push |-> out_free, "result register overwritten")
   `MBD_ASSERT(a_stall_holds_idx, stall |=> ($stable(idx_ff) && state_ff == SQ_RUN), "stall lost position")
   `MBD_ASSERT_ALWAYS(a_reset_clears, reset |=> (req_ready && !rsp_valid), "reset left block busy")

endmodule

FILE: hw/rtl/multi_button_debounce_press_hold.sv
// Debounce and press/hold/release detection for a bank of buttons.
// Request channel (req_valid/req_ready/req_payload): one transaction carries
// the level of every button (low = pressed) and the current millisecond time.
// A sample arriving sooner than poll_interval_ms after the last taken sample
// is dropped and gives no result.
// Result channel (rsp_valid/rsp_ready/rsp_payload): zero to four events per
// sample, in button order, with last_event set on the final one.
// Configuration (csr_we/csr_index/csr_wdata): write poll interval, stable
// threshold and long-press time while the block is idle; writes take effect
// at once.
// Timing: one shared button unit steps one button per cycle unless the walk
// is stalled; a sample passes through taking it, the poll check, one step
// per button and the release of the last event. A dropped sample passes
// only the take and the poll check. req_ready is high only between samples.
// Each event is held back until a later event or the release step hands it on.
// Stall: one event waits in the result register and one more is held back;
// a further event stalls the button walk until rsp_ready frees a slot.
// Reset: all buttons return to idle and released, the counters and the last
// poll time clear, and the configuration registers take their reset values.
module multi_button_debounce_press_hold (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  mbd_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mbd_pkg::rsp_type               rsp_payload,
   input  logic                           csr_we,
   input  logic [mbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mbd_pkg::*;

   logic [POLL_W-1:0]       poll_interval_ff;
   logic [THR_W-1:0]        stable_threshold_ff;
   logic [LONG_W-1:0]       long_press_ff;
   unit_ctrl_type           ctrl;
   logic [BUTTON_COUNT-1:0] levels;
   logic [TIME_W-1:0]       now;
   logic [TIME_W-1:0]       last_poll;
   logic [TIME_W-1:0]       diff;
   btn_event_type           evt;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff    <= POLL_INTERVAL_RESET;
         stable_threshold_ff <= STABLE_THRESHOLD_RESET;
         long_press_ff       <= LONG_PRESS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POLL_INTERVAL:    poll_interval_ff    <= csr_wdata[POLL_W-1:0];
            CSR_STABLE_THRESHOLD: stable_threshold_ff <= csr_wdata[THR_W-1:0];
            CSR_LONG_PRESS:       long_press_ff       <= csr_wdata[LONG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mbd_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .poll_interval_ms (poll_interval_ff),
      .ctrl             (ctrl),
      .levels           (levels),
      .now              (now),
      .last_poll        (last_poll),
      .diff             (diff),
      .evt              (evt)
   );

   mbd_btn_unit u_btn_unit (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .levels           (levels),
      .now              (now),
      .last_poll        (last_poll),
      .stable_threshold (stable_threshold_ff),
      .long_press_ms    (long_press_ff),
      .diff             (diff),
      .evt              (evt)
   );

endmodule
